FILE: rtl/afs_pkg.sv
`timescale 1ns / 1ps

package afs_pkg;

  // Mode codes
  localparam logic [2:0] MODE_PILOT = 3'd0;
  localparam logic [2:0] MODE_HOME  = 3'd1;

  // Failsafe levels
  typedef enum logic [1:0] {
    FS_NOMINAL  = 2'd0,
    FS_WARN     = 2'd1,
    FS_CRITICAL = 2'd2
  } fs_level_t;

  // Pre-arm reason codes
  localparam logic [2:0] RSN_OK        = 3'd0;
  localparam logic [2:0] RSN_NO_FIX    = 3'd1;
  localparam logic [2:0] RSN_LOW_BATT  = 3'd2;
  localparam logic [2:0] RSN_TILTED    = 3'd3;
  localparam logic [2:0] RSN_UNCHECKED = 3'd4;

  // Item commands
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CHECK  = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_LINK_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_MIN_ARM_MV   = 2'd1;
  localparam logic [1:0] REG_MAX_TILT     = 2'd2;
  localparam logic [1:0] REG_CRITICAL_MV  = 2'd3;

  localparam int APB_AW = 4;

  // Register reset values
  localparam logic [15:0] LINK_TIMEOUT_RST = 16'd1500;
  localparam logic [15:0] MIN_ARM_MV_RST   = 16'd7000;
  localparam logic [14:0] MAX_TILT_RST     = 15'd1500;
  localparam logic [29:0] TILT_SQ_RST      = 30'd2250000;
  localparam logic [15:0] CRITICAL_MV_RST  = 16'd6000;

  // Readings at or below this mean no battery sensor
  localparam logic [15:0] BATT_PRESENT_MV = 16'd500;

  typedef struct packed {
    logic [15:0] link_timeout_ms;
    logic [15:0] min_arm_mv;
    logic [29:0] tilt_sq;
    logic [15:0] critical_mv;
  } afs_cfg_t;

  typedef struct packed {
    logic        command;
    logic [2:0]  requested_mode;
    logic        request_arm;
    logic        gps_fix;
    logic [15:0] battery_mv;
    logic [30:0] roll_sq;
    logic [30:0] pitch_sq;
    logic [31:0] link_age_ms;
  } afs_item_t;

endpackage

FILE: rtl/afs_if.sv
`timescale 1ns / 1ps

interface afs_cmd_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [2:0]         requested_mode;
  logic               request_arm;
  logic               gps_fix;
  logic [15:0]        battery_mv;
  logic signed [15:0] roll_cdeg;
  logic signed [15:0] pitch_cdeg;
  logic [31:0]        link_age_ms;

  modport source (
    output valid, command, requested_mode, request_arm, gps_fix,
           battery_mv, roll_cdeg, pitch_cdeg, link_age_ms,
    input  ready
  );
  modport sink (
    input  valid, command, requested_mode, request_arm, gps_fix,
           battery_mv, roll_cdeg, pitch_cdeg, link_age_ms,
    output ready
  );
endinterface

interface afs_status_if;
  logic       valid;
  logic       ready;
  logic       armed;
  logic [2:0] mode;
  logic [2:0] last_mode;
  logic [1:0] failsafe_level;
  logic [2:0] reject_reason;
  logic       reset_controllers;

  modport source (
    output valid, armed, mode, last_mode, failsafe_level, reject_reason,
           reset_controllers,
    input  ready
  );
  modport sink (
    input  valid, armed, mode, last_mode, failsafe_level, reject_reason,
           reset_controllers,
    output ready
  );
endinterface

FILE: rtl/afs_cfg.sv
`timescale 1ns / 1ps

module afs_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [afs_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output afs_pkg::afs_cfg_t           cfg
);
  import afs_pkg::*;

  logic [15:0] link_timeout_ms;
  logic [15:0] min_arm_mv;
  logic [14:0] max_tilt_cdeg;
  logic [29:0] tilt_sq;
  logic [15:0] critical_mv;
  logic        wr_en;
  logic [1:0]  reg_idx;
  logic [29:0] tilt_prod;

  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite & pready;
  assign reg_idx   = paddr[3:2];
  // square the limit once at write time, off the item path
  assign tilt_prod = {15'd0, pwdata[14:0]} * {15'd0, pwdata[14:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      link_timeout_ms <= LINK_TIMEOUT_RST;
      min_arm_mv      <= MIN_ARM_MV_RST;
      max_tilt_cdeg   <= MAX_TILT_RST;
      tilt_sq         <= TILT_SQ_RST;
      critical_mv     <= CRITICAL_MV_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LINK_TIMEOUT: link_timeout_ms <= pwdata[15:0];
        REG_MIN_ARM_MV:   min_arm_mv      <= pwdata[15:0];
        REG_MAX_TILT: begin
          max_tilt_cdeg <= pwdata[14:0];
          tilt_sq       <= tilt_prod;
        end
        REG_CRITICAL_MV:  critical_mv     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LINK_TIMEOUT: prdata = {16'd0, link_timeout_ms};
      REG_MIN_ARM_MV:   prdata = {16'd0, min_arm_mv};
      REG_MAX_TILT:     prdata = {17'd0, max_tilt_cdeg};
      REG_CRITICAL_MV:  prdata = {16'd0, critical_mv};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg.link_timeout_ms = link_timeout_ms;
  assign cfg.min_arm_mv      = min_arm_mv;
  assign cfg.tilt_sq         = tilt_sq;
  assign cfg.critical_mv     = critical_mv;

endmodule

FILE: rtl/afs_front.sv
`timescale 1ns / 1ps

module afs_front (
  input  logic                clk,
  input  logic                rst,
  afs_cmd_if.sink             cmd,
  input  logic                take,
  output logic                item_valid,
  output afs_pkg::afs_item_t  item
);
  import afs_pkg::*;

  logic signed [31:0] roll_prod;
  logic signed [31:0] pitch_prod;

  assign roll_prod  = 32'(cmd.roll_cdeg) * 32'(cmd.roll_cdeg);
  assign pitch_prod = 32'(cmd.pitch_cdeg) * 32'(cmd.pitch_cdeg);

  // take a new transaction when empty or when the held one moves on
  assign cmd.ready = ~item_valid | take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item.command        <= cmd.command;
      item.requested_mode <= cmd.requested_mode;
      item.request_arm    <= cmd.request_arm;
      item.gps_fix        <= cmd.gps_fix;
      item.battery_mv     <= cmd.battery_mv;
      item.roll_sq        <= roll_prod[30:0];
      item.pitch_sq       <= pitch_prod[30:0];
      item.link_age_ms    <= cmd.link_age_ms;
    end
  end

endmodule

FILE: rtl/afs_core.sv
`timescale 1ns / 1ps

module afs_core (
  input  logic                clk,
  input  logic                rst,
  input  afs_pkg::afs_cfg_t   cfg,
  input  logic                item_valid,
  input  afs_pkg::afs_item_t  item,
  output logic                take,
  afs_status_if.source        status
);
  import afs_pkg::*;

  logic        arm_flag, arm_flag_next;
  logic [2:0]  mode_now, mode_now_next;
  logic [2:0]  mode_before, mode_before_next;
  fs_level_t   failsafe_now, failsafe_next;
  logic [2:0]  reason_code, reason_code_next;
  logic        pulse;
  logic [2:0]  prearm_code;
  logic [31:0] tilt_sum;
  logic [32:0] link_crit;
  logic        out_valid;

  assign take      = item_valid & (~out_valid | status.ready);
  assign tilt_sum  = {1'b0, item.roll_sq} + {1'b0, item.pitch_sq};
  assign link_crit = {16'd0, cfg.link_timeout_ms, 1'b0};

  always_comb begin
    if (!item.gps_fix) begin
      prearm_code = RSN_NO_FIX;
    end else if (item.battery_mv < cfg.min_arm_mv) begin
      prearm_code = RSN_LOW_BATT;
    end else if (tilt_sum > {2'd0, cfg.tilt_sq}) begin
      prearm_code = RSN_TILTED;
    end else begin
      prearm_code = RSN_OK;
    end
  end

  always_comb begin
    arm_flag_next    = arm_flag;
    mode_now_next    = mode_now;
    mode_before_next = mode_before;
    failsafe_next    = failsafe_now;
    reason_code_next = reason_code;
    pulse            = 1'b0;
    if (item.command == CMD_UPDATE) begin
      if (item.request_arm && !arm_flag) begin
        reason_code_next = prearm_code;
        if (prearm_code == RSN_OK) begin
          arm_flag_next = 1'b1;
          failsafe_next = FS_NOMINAL;
        end
      end else if (!item.request_arm && arm_flag) begin
        arm_flag_next = 1'b0;
        mode_now_next = MODE_PILOT;
        failsafe_next = FS_NOMINAL;
        pulse         = 1'b1;
      end
      if (arm_flag_next &&
          !(failsafe_next == FS_CRITICAL && item.requested_mode != MODE_HOME) &&
          item.requested_mode != mode_now_next) begin
        mode_before_next = mode_now_next;
        mode_now_next    = item.requested_mode;
        pulse            = 1'b1;
      end
    end else if (!arm_flag) begin
      failsafe_next = FS_NOMINAL;
    end else begin
      if ({1'b0, item.link_age_ms} > link_crit) begin
        if (failsafe_now != FS_CRITICAL) begin
          failsafe_next    = FS_CRITICAL;
          mode_before_next = mode_now;
          mode_now_next    = MODE_HOME;
          pulse            = 1'b1;
        end
      end else if (item.link_age_ms > {16'd0, cfg.link_timeout_ms}) begin
        if (failsafe_now == FS_NOMINAL) failsafe_next = FS_WARN;
      end else if (failsafe_now == FS_WARN) begin
        failsafe_next = FS_NOMINAL;
      end
      if (item.battery_mv > BATT_PRESENT_MV && item.battery_mv < cfg.critical_mv &&
          failsafe_next != FS_CRITICAL) begin
        failsafe_next    = FS_CRITICAL;
        mode_before_next = mode_now_next;
        mode_now_next    = MODE_HOME;
        pulse            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_flag     <= 1'b0;
      mode_now     <= MODE_PILOT;
      mode_before  <= MODE_PILOT;
      failsafe_now <= FS_NOMINAL;
      reason_code  <= RSN_UNCHECKED;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        arm_flag     <= arm_flag_next;
        mode_now     <= mode_now_next;
        mode_before  <= mode_before_next;
        failsafe_now <= failsafe_next;
        reason_code  <= reason_code_next;
        out_valid    <= 1'b1;
      end else if (status.ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status.armed             <= arm_flag_next;
      status.mode              <= mode_now_next;
      status.last_mode         <= mode_before_next;
      status.failsafe_level    <= failsafe_next;
      status.reject_reason     <= reason_code_next;
      status.reset_controllers <= pulse;
    end
  end

  assign status.valid = out_valid;

endmodule

FILE: rtl/arm_mode_failsafe_supervisor.sv
`timescale 1ns / 1ps

// Channel   Dir   Handshake        Transaction contents
// cmd       in    valid / ready    command, requested_mode, request_arm, gps_fix,
//                                  battery_mv, roll_cdeg, pitch_cdeg, link_age_ms
// status    out   valid / ready    armed, mode, last_mode, failsafe_level,
//                                  reject_reason, reset_controllers
// apb       cfg   psel / penable   link_timeout_ms @0x0, min_arm_mv @0x4,
//                                  max_tilt_cdeg @0x8, critical_mv @0xC
//
// One transaction per cycle unless the result stalls. The input register
// captures the transaction with roll and pitch already squared; the decision
// stage then updates the supervisor state and loads the result register, so
// a transaction reaches status through the input and result registers in turn.
// rst is synchronous; it restores register defaults and the disarmed state.
// A stalled result holds; one more transaction fills the input register
// behind it, then cmd.ready drops until the result is taken.

module arm_mode_failsafe_supervisor (
  input  logic                        clk,
  input  logic                        rst,
  afs_cmd_if.sink                     cmd,
  afs_status_if.source                status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [afs_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import afs_pkg::*;

  afs_cfg_t  cfg;
  afs_item_t item;
  logic      item_valid;
  logic      take;

  // Configuration registers; the tilt limit is kept squared as well
  afs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register: capture the transaction and the attitude squares
  afs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Decision stage: arm checks, mode change and failsafe grading, then hold
  // the result until the sink takes it
  afs_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .status     (status)
  );

  // A disarmed vehicle always sits in manual mode at nominal level
  a_disarmed_manual: assert property (@(posedge clk) disable iff (rst)
    status.valid && !status.armed |->
      status.mode == MODE_PILOT && status.failsafe_level == FS_NOMINAL)
    else $error("disarmed result not in manual/nominal");

  // Critical failsafe only while armed and flying home
  a_critical_home: assert property (@(posedge clk) disable iff (rst)
    status.valid && status.failsafe_level == FS_CRITICAL |->
      status.armed && status.mode == MODE_HOME)
    else $error("critical failsafe without return-home");

  // Being armed means the last pre-arm check passed
  a_armed_ok: assert property (@(posedge clk) disable iff (rst)
    status.valid && status.armed |-> status.reject_reason == RSN_OK)
    else $error("armed with a pending reject reason");

endmodule
